/* rtl/core/mexp_pkg.sv */
// Shared constants and types for the modular exponentiation block.
// No dependencies; imported by the core and its checker.
package mexp_pkg;
	localparam int WIDTH  = 32;
	localparam int CNT_W  = $clog2(WIDTH);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [WIDTH-1:0] EXP_RESET = WIDTH'(65537);
	localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(1);

	typedef enum logic {
		REG_EXPONENT,
		REG_MODULUS
	} reg_idx_t;
endpackage

/* rtl/core/modular_exponentiation.sv */
// From start to done: the base is reduced modulo the modulus one bit at a time, then one
// modular multiply (square or multiply) per exponent step, each bit-serial shift-add;
// when the modulus is zero the block goes straight to its done state.
// One base at a time: busy stays high from start until done. The bit-serial
// shift-add multiplier does one modular add per cycle. The receiver cannot stall.
// Reset (arst_n low): idle, exponent 65537, modulus 1, no result pending. Depends on mexp_pkg.
module modular_exponentiation (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mexp_pkg::ADDR_W-1:0]  paddr,
	input  logic [mexp_pkg::DATA_W-1:0]  pwdata,
	output logic [mexp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         start,
	input  logic [mexp_pkg::WIDTH-1:0]   base,
	output logic                         busy,
	output logic                         done,
	output logic [mexp_pkg::WIDTH-1:0]   power_mod
);
	import mexp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RED,
		ST_MUL,
		ST_DONE
	} state_t;

	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
			input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] m);
		logic [WIDTH:0]   s;
		logic [WIDTH+1:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = {1'b0, s} - {2'b0, m};
		return d[WIDTH+1] ? s[WIDTH-1:0] : d[WIDTH-1:0];
	endfunction

	state_t           state_q;
	logic [WIDTH-1:0] exp_q, mod_q;
	logic             done_q;
	logic [WIDTH-1:0] power_mod_q;

	logic [WIDTH-1:0] e_q, b_q, sq_q, acc_q, x_q, y_q, p_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q, sqr_q;

	logic             cfg_wr, accept;
	logic [WIDTH:0]   red_t;
	logic [WIDTH+1:0] red_d;
	logic [WIDTH-1:0] red_val;
	logic [WIDTH-1:0] p_next;
	logic             bit_done, end_op, go_done, go_sqr;
	logic [WIDTH-1:0] new_sq, new_e, new_acc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign power_mod = power_mod_q;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_EXPONENT: prdata = DATA_W'(exp_q);
			REG_MODULUS:  prdata = DATA_W'(mod_q);
			default:      prdata = '0;
		endcase
	end

	assign red_t   = {sq_q, b_q[WIDTH-1]};
	assign red_d   = {1'b0, red_t} - {2'b0, mod_q};
	assign red_val = red_d[WIDTH+1] ? red_t[WIDTH-1:0] : red_d[WIDTH-1:0];

	assign p_next   = add_mod(p_q, phase_q ? x_q : p_q, mod_q);
	assign bit_done = phase_q || !y_q[WIDTH-1];

	always_comb begin
		end_op  = ((state_q == ST_RED) && (cnt_q == '0)) ||
			((state_q == ST_MUL) && bit_done && (cnt_q == '0));
		new_sq  = (state_q == ST_RED) ? red_val : (sqr_q ? p_next : sq_q);
		new_e   = ((state_q == ST_MUL) && sqr_q) ? (e_q >> 1) : e_q;
		new_acc = ((state_q == ST_MUL) && !sqr_q) ? p_next : acc_q;
		go_done = 1'b0;
		go_sqr  = 1'b1;
		if (!((state_q == ST_MUL) && !sqr_q)) begin
			if (new_e == '0) begin
				go_done = 1'b1;
			end else if (new_e[0]) begin
				go_sqr = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= EXP_RESET;
			mod_q       <= MOD_RESET;
			done_q      <= 1'b0;
			power_mod_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				unique case (reg_idx_t'(paddr[2]))
					REG_EXPONENT: exp_q <= pwdata[WIDTH-1:0];
					REG_MODULUS:  mod_q <= pwdata[WIDTH-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (mod_q == '0) ? ST_DONE : ST_RED;
					end
				end
				ST_RED, ST_MUL: begin
					if (end_op) begin
						state_q <= go_done ? ST_DONE : ST_MUL;
					end
				end
				ST_DONE: begin
					done_q      <= 1'b1;
					power_mod_q <= acc_q;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					e_q   <= exp_q;
					b_q   <= base;
					sq_q  <= '0;
					acc_q <= {{(WIDTH-1){1'b0}}, (mod_q > WIDTH'(1))};
					cnt_q <= CNT_W'(WIDTH-1);
				end
			end
			ST_RED: begin
				sq_q  <= red_val;
				b_q   <= b_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_MUL: begin
				p_q <= p_next;
				if (!phase_q && y_q[WIDTH-1]) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					y_q     <= y_q << 1;
					cnt_q   <= cnt_q - 1'b1;
				end
			end
			default: ;
		endcase
		if (end_op) begin
			sq_q    <= new_sq;
			e_q     <= new_e;
			acc_q   <= new_acc;
			x_q     <= new_sq;
			y_q     <= go_sqr ? new_sq : new_acc;
			sqr_q   <= go_sqr;
			p_q     <= '0;
			phase_q <= 1'b0;
			cnt_q   <= CNT_W'(WIDTH-1);
		end
	end
endmodule

/* rtl/core/mexp_checker.sv */
// Port-level checks on the modular exponentiation handshake and result timing.
// Depends on mexp_pkg; bound to modular_exponentiation below.
module mexp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [mexp_pkg::WIDTH-1:0]   power_mod
);
	import mexp_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!done && !$past(busy) && !busy |-> $stable(power_mod))
		else $error("result changed while idle");
endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.power_mod (power_mod)
);
